// ===== hw/rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// shared types, constants and the collapsed-text step for the paragraph splitter
// ----------------------------------------------------------------------------
package tps_pkg;

	localparam int RAW_W = 13;
	localparam logic [RAW_W-1:0] MAX_PARA_BYTES = 13'd4096;

	localparam logic [15:0] PAT_CRLF = 16'h0d0a;
	localparam logic [15:0] PAT_CRCR = 16'h0d0d;
	localparam logic [15:0] PAT_LFLF = 16'h0a0a;
	localparam logic [7:0] SOFT_HYPHEN = 8'hAD;
	localparam logic [7:0] BLANK_TOP = 8'd32;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_MATCH = 2'd1;
	localparam logic [31:0] SEP_MASK_RST = 32'h0000_00FF;
	localparam logic [31:0] SEP_MATCH_RST = 32'h0000_000A;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;
	localparam int FIFO_CW = 3;

	typedef struct packed {
		logic [31:0] para_offset;
		logic [RAW_W-1:0] raw_length;
		logic [31:0] text_start;
		logic is_end_marker;
		logic last;
	} result_t;

	typedef struct packed {
		logic push0;
		logic push1;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic [RAW_W-1:0] len;
		logic word_seen;
		logic blank_pending;
		logic inside_word;
	} text_state_t;

	function automatic text_state_t feed_text(text_state_t s, logic [7:0] c);
		text_state_t n;
		logic blank;
		logic space;
		n = s;
		blank = (c <= BLANK_TOP);
		space = blank || (c == SOFT_HYPHEN);
		if (!s.word_seen) begin
			if (!space) begin
				n.word_seen = 1'b1;
				n.inside_word = 1'b1;
				n.len = s.len + 13'd1;
			end
		end else if (s.inside_word) begin
			if (blank) begin
				n.inside_word = 1'b0;
				n.blank_pending = 1'b1;
			end else if (c != SOFT_HYPHEN) begin
				n.len = s.len + 13'd1;
			end
		end else if (!space) begin
			n.len = s.len + 13'd2;
			n.inside_word = 1'b1;
			n.blank_pending = 1'b0;
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/tps_rfifo.sv =====
// ----------------------------------------------------------------------------
// tps_rfifo
// four-entry result queue, takes one or two results per cycle, gives one
// ----------------------------------------------------------------------------
module tps_rfifo (
	input  logic clk,
	input  logic arst_n,
	input  tps_pkg::fifo_ctl_t ctl,
	input  tps_pkg::result_t wdata0,
	input  tps_pkg::result_t wdata1,
	output tps_pkg::result_t rdata,
	output logic [tps_pkg::FIFO_CW-1:0] count,
	output logic not_empty
);

	tps_pkg::result_t mem_q [tps_pkg::FIFO_DEPTH];
	logic [tps_pkg::FIFO_AW-1:0] wr_q;
	logic [tps_pkg::FIFO_AW-1:0] rd_q;
	logic [tps_pkg::FIFO_CW-1:0] count_q;
	logic [tps_pkg::FIFO_AW-1:0] wr_next;
	logic [tps_pkg::FIFO_CW-1:0] n_push;

	assign wr_next = wr_q + {{(tps_pkg::FIFO_AW-1){1'b0}}, 1'b1};
	assign n_push = {{(tps_pkg::FIFO_CW-1){1'b0}}, ctl.push0}
		+ {{(tps_pkg::FIFO_CW-1){1'b0}}, ctl.push1};

	always_ff @(posedge clk) begin
		if (ctl.push0) begin
			mem_q[wr_q] <= wdata0;
		end
		if (ctl.push1) begin
			mem_q[wr_next] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + n_push[tps_pkg::FIFO_AW-1:0];
			if (ctl.pop) begin
				rd_q <= rd_q + {{(tps_pkg::FIFO_AW-1){1'b0}}, 1'b1};
			end
			count_q <= count_q + n_push - {{(tps_pkg::FIFO_CW-1){1'b0}}, ctl.pop};
		end
	end

	assign rdata = mem_q[rd_q];
	assign count = count_q;
	assign not_empty = (count_q != '0);

`ifndef SYNTHESIS
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push1 |-> ctl.push0)
		else $error("second result pushed without the first");
	a_room_pair: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push1 |-> (count_q <= 3'd2))
		else $error("result pair pushed without room");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> (count_q != 3'd0))
		else $error("pop from empty result queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push0 && !ctl.push1 && !ctl.pop) |=> (count_q == $past(count_q) + 3'd1))
		else $error("queue count did not follow a single push");
`endif

endmodule

// ===== hw/rtl/text_paragraph_splitter.sv =====
// ----------------------------------------------------------------------------
// text_paragraph_splitter
// splits a byte stream of single-byte text into paragraph records
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall, one text byte or an end-of-stream flag
//     per transfer; one transfer per cycle is taken while results drain
//   output channel: out_valid / out_stall, one paragraph record per transfer
//   config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//     sep_mask (0) or sep_match (1); other indexes are dropped
// path: an accepted input is held in the input register, its results are then
//   written into the four-entry result queue and transfer from its head
// throughput: one byte per cycle while in_stall is low; an end-of-stream transfer
//   yields two records (last paragraph and end marker) that leave one after the other
// the input register advances while empty or while the result queue has at least
//   two free entries, so a stalled receiver backs up into in_stall
// reset: all counters and the byte history clear, sep_mask = 0xFF,
//   sep_match = 0x0A; after an end marker the stream state clears again and
//   offsets restart at 0
// ----------------------------------------------------------------------------
module text_paragraph_splitter (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] data_byte,
	input  logic end_of_stream,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] para_offset,
	output logic [tps_pkg::RAW_W-1:0] raw_length,
	output logic [31:0] text_start,
	output logic is_end_marker,
	output logic last
);

	logic [31:0] sep_mask_q;
	logic [31:0] sep_match_q;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eos_s1;

	logic [31:0] history_q;
	logic [tps_pkg::RAW_W-1:0] raw_count_q;
	logic [31:0] start_q;
	logic [31:0] position_q;
	logic [31:0] total_q;
	tps_pkg::text_state_t text_q;

	tps_pkg::fifo_ctl_t fctl;
	tps_pkg::result_t res0;
	tps_pkg::result_t res1;
	tps_pkg::result_t head;
	logic [tps_pkg::FIFO_CW-1:0] fcount;
	logic fnot_empty;

	logic advance;
	logic work;
	logic [31:0] hist_new;
	logic is_full;
	logic is_sep;
	logic cut;
	tps_pkg::text_state_t text_fed;
	tps_pkg::text_state_t text_fresh;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_mask_q <= tps_pkg::SEP_MASK_RST;
			sep_match_q <= tps_pkg::SEP_MATCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tps_pkg::REG_SEP_MASK: sep_mask_q <= cfg_data;
				tps_pkg::REG_SEP_MATCH: sep_match_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign advance = !valid_s1 || (fcount <= 3'd2);
	assign in_stall = !advance;
	assign work = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			byte_s1 <= data_byte;
			eos_s1 <= end_of_stream;
		end
	end

	// separator and overflow detection
	assign hist_new = {history_q[23:0], byte_s1};
	assign is_full = (raw_count_q >= tps_pkg::MAX_PARA_BYTES);
	assign is_sep = (hist_new[15:0] == tps_pkg::PAT_CRLF)
		|| (hist_new[15:0] == tps_pkg::PAT_CRCR)
		|| (hist_new[15:0] == tps_pkg::PAT_LFLF)
		|| ((hist_new & sep_mask_q) == sep_match_q);
	assign cut = is_full || is_sep;

	assign text_fed = tps_pkg::feed_text(text_q, byte_s1);
	assign text_fresh = tps_pkg::feed_text('0, byte_s1);

	// result records
	always_comb begin
		res0.para_offset = start_q;
		res0.raw_length = raw_count_q;
		res0.text_start = total_q;
		res0.is_end_marker = 1'b0;
		res0.last = !eos_s1;
		res1.para_offset = '0;
		res1.raw_length = '0;
		res1.text_start = total_q + {19'd0, text_q.len};
		res1.is_end_marker = 1'b1;
		res1.last = 1'b1;
		fctl.push0 = work && (eos_s1 || cut);
		fctl.push1 = work && eos_s1;
		fctl.pop = fnot_empty && !out_stall;
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			raw_count_q <= '0;
			start_q <= '0;
			position_q <= '0;
			total_q <= '0;
			text_q <= '0;
		end else if (work) begin
			if (eos_s1) begin
				history_q <= '0;
				raw_count_q <= '0;
				start_q <= '0;
				position_q <= '0;
				total_q <= '0;
				text_q <= '0;
			end else begin
				history_q <= hist_new;
				position_q <= position_q + 32'd1;
				if (cut) begin
					total_q <= total_q + {19'd0, text_q.len};
					if (is_full) begin
						start_q <= position_q;
						raw_count_q <= 13'd1;
						text_q <= text_fresh;
					end else begin
						start_q <= position_q + 32'd1;
						raw_count_q <= '0;
						text_q <= '0;
					end
				end else begin
					raw_count_q <= raw_count_q + 13'd1;
					text_q <= text_fed;
				end
			end
		end
	end

	tps_rfifo u_rfifo (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(fctl),
		.wdata0(res0),
		.wdata1(res1),
		.rdata(head),
		.count(fcount),
		.not_empty(fnot_empty)
	);

	assign out_valid = fnot_empty;
	assign para_offset = head.para_offset;
	assign raw_length = head.raw_length;
	assign text_start = head.text_start;
	assign is_end_marker = head.is_end_marker;
	assign last = head.last;

`ifndef SYNTHESIS
	a_raw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		raw_count_q <= tps_pkg::MAX_PARA_BYTES)
		else $error("paragraph byte count beyond limit");
	a_text_bound: assert property (@(posedge clk) disable iff (!arst_n)
		text_q.len <= raw_count_q)
		else $error("collapsed length exceeds raw length");
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(work && eos_s1) |=> (position_q == 32'd0 && total_q == 32'd0))
		else $error("stream state not cleared after end marker");
`endif

endmodule
